>>> rtl/cwst_pkg.sv
// shared types, codes and constants of the wheel and steering telemetry gateway
package cwst_pkg;

  // request kinds on the input channel
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // identifiers seen and sent
  localparam logic [10:0] ID_WHEEL_IN = 11'h0CE;
  localparam logic [10:0] ID_STEER_IN = 11'h0C4;
  localparam logic [10:0] ID_TELE_OUT = 11'h6D3;
  localparam logic [10:0] ID_CFG_OUT  = 11'h6D1;
  localparam logic [10:0] ID_ACK_OUT  = 11'h6D2;
  localparam logic [10:0] ID_STAT_OUT = 11'h6D5;

  localparam logic [3:0] WHEEL_LEN = 4'd8;
  localparam logic [3:0] STEER_MIN_LEN = 4'd2;

  // multiplexer bytes
  localparam logic [7:0] MUX_WHEEL = 8'h60;
  localparam logic [7:0] MUX_STEER = 8'h80;

  // fixed-point scaling, Q16
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [32:0] ROUND_HALF = 33'd32768;
  localparam logic signed [33:0] STEER_CENTRE_Q = 34'sd163840000;  // 2500 mV in Q16
  localparam logic [29:0] STEER_MAX_Q = 30'd327680000;              // 5000 mV in Q16
  localparam logic [15:0] MV_CENTRE = 16'd2500;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_WHEEL_GAIN  = 3'd0,
    CFG_STEER_GAIN  = 3'd1,
    CFG_STALE_MS    = 3'd2,
    CFG_TELE_MS     = 3'd3,
    CFG_KEEP_MS     = 3'd4,
    CFG_ACK_MS      = 3'd5,
    CFG_LED_MS      = 3'd6
  } cfg_index_t;

  // register reset values
  localparam logic [15:0] RST_WHEEL_GAIN = 16'd35001;
  localparam logic [15:0] RST_STEER_GAIN = 16'd30341;
  localparam logic [15:0] RST_STALE_MS   = 16'd2000;
  localparam logic [15:0] RST_TELE_MS    = 16'd50;
  localparam logic [15:0] RST_KEEP_MS    = 16'd500;
  localparam logic [15:0] RST_ACK_MS     = 16'd490;
  localparam logic [15:0] RST_LED_MS     = 16'd250;

  typedef struct packed {
    logic [15:0] wheel_gain;
    logic [15:0] steer_gain;
    logic [15:0] stale_timeout_ms;
    logic [15:0] tele_period_ms;
    logic [15:0] keepalive_period_ms;
    logic [15:0] ack_period_ms;
    logic [15:0] led_period_ms;
  } cfg_t;

  // frame slots of one tick, in emission order
  localparam int unsigned NUM_STEPS = 11;
  typedef logic [NUM_STEPS-1:0] step_mask_t;
  typedef logic [3:0] step_t;
  localparam step_t STEP_WHEEL0 = 4'd0;
  localparam step_t STEP_WHEEL3 = 4'd3;
  localparam step_t STEP_STEER  = 4'd4;
  localparam step_t STEP_CFG0   = 4'd5;
  localparam step_t STEP_CFG3   = 4'd8;
  localparam step_t STEP_ACK    = 4'd9;
  localparam step_t STEP_STATUS = 4'd10;

  // one tick's burst as handed from front to back
  typedef struct packed {
    step_mask_t         mask;
    logic [3:0][15:0]   wheel;
    logic               steer_ok;
    logic signed [33:0] steer_q;
    logic               led;
  } burst_t;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

>>> rtl/cwst_if.sv
// channel interfaces: request input and frame output
interface cwst_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [10:0] frame_id;
  logic [3:0]  frame_len;
  logic [63:0] frame_data;

  modport source (output valid, kind, frame_id, frame_len, frame_data, input ready);
  modport sink   (input valid, kind, frame_id, frame_len, frame_data, output ready);
endinterface

interface cwst_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] out_id;
  logic [63:0] out_data;
  logic        last_frame;
  logic        led_level;

  modport source (output valid, out_id, out_data, last_frame, led_level, input ready);
  modport sink   (input valid, out_id, out_data, last_frame, led_level, output ready);
endinterface

>>> rtl/cwst_front.sv
// front end: latches received frames, runs the millisecond timers, queues bursts
module cwst_front (
  input  logic                 clk,
  input  logic                 rst,
  input  cwst_pkg::cfg_t       cfg,
  cwst_in_if.sink              in_ch,
  input  logic                 full,
  output logic                 push,
  output cwst_pkg::burst_t     push_burst
);

  logic [31:0]      time_ms;
  logic [3:0][15:0] wheel_speed;
  logic [15:0]      steer_angle;
  logic             steer_ok;
  logic [31:0]      steer_seen_ms;
  logic [31:0]      tele_sent_ms;
  logic [31:0]      keepalive_sent_ms;
  logic [31:0]      ack_sent_ms;
  logic [31:0]      led_toggled_ms;
  logic             led_state;

  logic             accept;
  logic             tick;
  logic [31:0]      time_next;
  logic             led_due;
  logic             led_next;
  logic             stale;
  logic             steer_ok_next;
  logic             tele_due;
  logic             keep_due;
  logic             ack_due;
  logic signed [33:0] steer_q;

  // a tick needs a free queue slot, so requests wait while the queue is full
  assign in_ch.ready = !full;
  assign accept = in_ch.valid && in_ch.ready;
  assign tick = accept && (in_ch.kind == cwst_pkg::KIND_TICK);

  // interval tests against the advanced time, wrapping 32-bit arithmetic
  always_comb begin
    time_next = time_ms + 32'd1;
    led_due   = (time_next - led_toggled_ms) >= 32'(cfg.led_period_ms);
    led_next  = led_state ^ led_due;
    stale     = (time_next - steer_seen_ms) > 32'(cfg.stale_timeout_ms);
    steer_ok_next = steer_ok && !stale;
    tele_due  = (time_next - tele_sent_ms) >= 32'(cfg.tele_period_ms);
    keep_due  = (time_next - keepalive_sent_ms) >= 32'(cfg.keepalive_period_ms);
    ack_due   = (time_next - ack_sent_ms) >= 32'(cfg.ack_period_ms);
  end

  // steering offset in q16, clamped and rounded later in the back end
  assign steer_q = cwst_pkg::STEER_CENTRE_Q
                   + 34'(signed'(steer_angle)) * 34'(signed'({1'b0, cfg.steer_gain}));

  // burst descriptor: which slots are due and a snapshot of the values
  always_comb begin
    push_burst.mask = '0;
    for (int i = 0; i < 5; i++) begin
      push_burst.mask[i] = tele_due;
    end
    for (int i = 5; i < 9; i++) begin
      push_burst.mask[i] = keep_due;
    end
    push_burst.mask[cwst_pkg::STEP_ACK]    = ack_due;
    push_burst.mask[cwst_pkg::STEP_STATUS] = keep_due;
    push_burst.wheel    = wheel_speed;
    push_burst.steer_ok = steer_ok_next;
    push_burst.steer_q  = steer_q;
    push_burst.led      = led_next;
  end

  assign push = tick && (push_burst.mask != '0);

  // gateway state
  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms           <= '0;
      wheel_speed       <= '0;
      steer_angle       <= '0;
      steer_ok          <= 1'b0;
      steer_seen_ms     <= '0;
      tele_sent_ms      <= '0;
      keepalive_sent_ms <= '0;
      ack_sent_ms       <= '0;
      led_toggled_ms    <= '0;
      led_state         <= 1'b0;
    end else if (tick) begin
      time_ms   <= time_next;
      led_state <= led_next;
      steer_ok  <= steer_ok_next;
      if (led_due) begin
        led_toggled_ms <= time_next;
      end
      if (tele_due) begin
        tele_sent_ms <= time_next;
      end
      if (keep_due) begin
        keepalive_sent_ms <= time_next;
      end
      if (ack_due) begin
        ack_sent_ms <= time_next;
      end
    end else if (accept) begin
      if (in_ch.frame_id == cwst_pkg::ID_WHEEL_IN && in_ch.frame_len == cwst_pkg::WHEEL_LEN) begin
        wheel_speed <= in_ch.frame_data;
      end
      if (in_ch.frame_id == cwst_pkg::ID_STEER_IN
          && in_ch.frame_len >= cwst_pkg::STEER_MIN_LEN) begin
        steer_angle   <= in_ch.frame_data[15:0];
        steer_ok      <= 1'b1;
        steer_seen_ms <= time_ms;
      end
    end
  end

`ifndef SYNTHESIS
  // time moves by one on each tick and never on a received frame
  assert property (@(posedge clk) disable iff (rst)
    tick |=> time_ms == $past(time_ms) + 32'd1)
    else $error("time did not advance by one on a tick");

  assert property (@(posedge clk) disable iff (rst)
    (accept && !tick) |=> time_ms == $past(time_ms))
    else $error("time moved on a received frame");

  // no burst may be pushed into a full queue
  assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("burst pushed while queue full");
`endif

endmodule

>>> rtl/cwst_queue.sv
// short burst queue between front and back end
module cwst_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cwst_pkg::burst_t push_burst,
  input  logic             pop,
  output cwst_pkg::burst_t head,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PtrW = $clog2(cwst_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(cwst_pkg::QUEUE_DEPTH + 1);

  cwst_pkg::burst_t mem [cwst_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign full  = (count == CntW'(cwst_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_burst;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(cwst_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !empty)
    else $error("queue empty after push");
`endif

endmodule

>>> rtl/cwst_back.sv
// back end: walks the due slots of each burst and builds one frame per cycle while the output is not stalled
module cwst_back (
  input  logic             clk,
  input  logic             rst,
  input  cwst_pkg::cfg_t   cfg,
  input  cwst_pkg::burst_t head,
  input  logic             empty,
  output logic             pop,
  cwst_out_if.source       out_ch
);

  cwst_pkg::step_mask_t sent;
  cwst_pkg::step_mask_t pend;
  cwst_pkg::step_mask_t pick;
  cwst_pkg::step_mask_t rest;
  cwst_pkg::step_t      step;
  logic                 advance;
  logic                 emit;
  logic                 last;

  logic [1:0]           lane;
  logic [15:0]          speed;
  logic [32:0]          wheel_sum;
  logic [15:0]          hz;
  logic [29:0]          steer_clamped;
  logic [29:0]          steer_round;
  logic [15:0]          mv;
  logic [15:0]          mv_sel;
  logic [10:0]          id_next;
  logic [63:0]          data_next;

  logic                 out_valid;
  logic [10:0]          out_id;
  logic [63:0]          out_data;
  logic                 last_frame;
  logic                 led_level;

  // slot selection: lowest slot still pending in the head burst
  always_comb begin
    pend = head.mask & ~sent;
    pick = pend & (~pend + cwst_pkg::step_mask_t'(1));
    rest = pend & ~pick;
    last = (rest == '0);
    step = '0;
    for (int i = 0; i < cwst_pkg::NUM_STEPS; i++) begin
      if (pick[i]) begin
        step = step | cwst_pkg::step_t'(i);
      end
    end
  end

  assign advance = !out_valid || out_ch.ready;
  assign emit    = !empty && advance;
  assign pop     = emit && last;

  // wheel frequency, q16 with round half up
  always_comb begin
    lane      = 2'(step - cwst_pkg::STEP_WHEEL0);
    speed     = head.wheel[lane];
    wheel_sum = 33'(speed) * 33'(cfg.wheel_gain) + cwst_pkg::ROUND_HALF;
    hz        = wheel_sum[31:16];
  end

  // steering millivolts, clamped to the output range then rounded
  always_comb begin
    if (head.steer_q < 0) begin
      steer_clamped = '0;
    end else if (head.steer_q > 34'(cwst_pkg::STEER_MAX_Q)) begin
      steer_clamped = cwst_pkg::STEER_MAX_Q;
    end else begin
      steer_clamped = head.steer_q[29:0];
    end
    steer_round = steer_clamped + 30'(cwst_pkg::ROUND_HALF);
    mv          = 16'(steer_round[29:cwst_pkg::FRAC_BITS]);
    mv_sel      = head.steer_ok ? mv : cwst_pkg::MV_CENTRE;
  end

  // frame contents per slot
  always_comb begin
    id_next   = cwst_pkg::ID_STAT_OUT;
    data_next = '0;
    case (step) inside
      [cwst_pkg::STEP_WHEEL0:cwst_pkg::STEP_WHEEL3]: begin
        id_next   = cwst_pkg::ID_TELE_OUT;
        data_next = {hz[7:0], hz[15:8], 8'hF4, 8'h01, 8'h88, 8'h13, 8'h01,
                     cwst_pkg::MUX_WHEEL + 8'(lane)};
      end
      cwst_pkg::STEP_STEER: begin
        id_next   = cwst_pkg::ID_TELE_OUT;
        data_next = {32'd0, mv_sel[7:0], mv_sel[15:8], 7'd0, head.steer_ok,
                     cwst_pkg::MUX_STEER};
      end
      [cwst_pkg::STEP_CFG0:cwst_pkg::STEP_CFG3]: begin
        id_next   = cwst_pkg::ID_CFG_OUT;
        data_next = {8'h00, 8'h01, 8'h13, 8'h88, 8'h00, 8'h00, 8'h03,
                     cwst_pkg::MUX_WHEEL + 8'(2'(step - cwst_pkg::STEP_CFG0))};
      end
      cwst_pkg::STEP_ACK: begin
        id_next   = cwst_pkg::ID_ACK_OUT;
        data_next = {8'h01, 56'd0};
      end
      cwst_pkg::STEP_STATUS: begin
        id_next   = cwst_pkg::ID_STAT_OUT;
        data_next = {8'h04, 8'h03, 8'h02, 8'h01, 32'd0};
      end
      default: begin
        id_next   = cwst_pkg::ID_STAT_OUT;
        data_next = '0;
      end
    endcase
  end

  // progress through the head burst
  always_ff @(posedge clk) begin
    if (rst) begin
      sent <= '0;
    end else if (emit) begin
      if (last) begin
        sent <= '0;
      end else begin
        sent <= sent | pick;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_id     <= id_next;
      out_data   <= data_next;
      last_frame <= last;
      led_level  <= head.led;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_id     = out_id;
  assign out_ch.out_data   = out_data;
  assign out_ch.last_frame = last_frame;
  assign out_ch.led_level  = led_level;

`ifndef SYNTHESIS
  // a frame is only built from a slot that is still pending
  assert property (@(posedge clk) disable iff (rst)
    emit |-> $onehot(pick))
    else $error("frame built with no pending slot");

  // slots marked done always belong to the head burst
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (sent & ~head.mask) == '0)
    else $error("done slot outside head burst");

  // retiring a burst leaves its last frame in the output register
  assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid && last_frame)
    else $error("burst retired without a last frame");
`endif

endmodule

>>> rtl/can_wheel_steer_telemetry_gateway.sv
// top level: configuration registers, front end, burst queue and back end
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  in_ch    | in  | valid/ready   | kind, frame_id, frame_len, frame_data
//  out_ch   | out | valid/ready   | out_id, out_data, last_frame, led_level
//  cfg      | in  | cfg_write     | cfg_index, cfg_data (16 bits, no read-back)
//
//  a received frame is taken and yields nothing; a tick is taken and yields 0 to 11 frames,
//  one per cycle while the output is not stalled, out of the back end's slot walk.
//  the front end takes a request in every cycle while the two-entry burst queue has room.
//  an output stall holds the back end only; the front end keeps going until the queue fills.
//  reset is synchronous and clears all timers, latched values and the queue.
module can_wheel_steer_telemetry_gateway (
  input  logic        clk,
  input  logic        rst,
  cwst_in_if.sink     in_ch,
  cwst_out_if.source  out_ch,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cwst_pkg::cfg_t   cfg;
  cwst_pkg::burst_t push_burst;
  cwst_pkg::burst_t head;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheel_gain          <= cwst_pkg::RST_WHEEL_GAIN;
      cfg.steer_gain          <= cwst_pkg::RST_STEER_GAIN;
      cfg.stale_timeout_ms    <= cwst_pkg::RST_STALE_MS;
      cfg.tele_period_ms      <= cwst_pkg::RST_TELE_MS;
      cfg.keepalive_period_ms <= cwst_pkg::RST_KEEP_MS;
      cfg.ack_period_ms       <= cwst_pkg::RST_ACK_MS;
      cfg.led_period_ms       <= cwst_pkg::RST_LED_MS;
    end else if (cfg_write) begin
      case (cfg_index)
        cwst_pkg::CFG_WHEEL_GAIN: cfg.wheel_gain          <= cfg_data;
        cwst_pkg::CFG_STEER_GAIN: cfg.steer_gain          <= cfg_data;
        cwst_pkg::CFG_STALE_MS:   cfg.stale_timeout_ms    <= cfg_data;
        cwst_pkg::CFG_TELE_MS:    cfg.tele_period_ms      <= cfg_data;
        cwst_pkg::CFG_KEEP_MS:    cfg.keepalive_period_ms <= cfg_data;
        cwst_pkg::CFG_ACK_MS:     cfg.ack_period_ms       <= cfg_data;
        cwst_pkg::CFG_LED_MS:     cfg.led_period_ms       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cwst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .full       (full),
    .push       (push),
    .push_burst (push_burst)
  );

  cwst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_burst (push_burst),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  cwst_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

>>> test/can_wheel_steer_telemetry_gateway_tb.sv
// testbench for the wheel and steering telemetry gateway: directed and random requests
module can_wheel_steer_telemetry_gateway_tb;

  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;

  // millivolt range in Q16
  localparam logic signed [47:0] MV_MID_Q = 48'sd163840000;
  localparam logic signed [47:0] MV_TOP_Q = 48'sd327680000;

  // fixed payload bytes of the emitted frames
  localparam logic [39:0] WHEEL_TELE_FILL = 40'hF4_01_88_13_01;        // bytes 1 to 5
  localparam logic [55:0] CFG_FILL        = 56'h00_01_13_88_00_00_03;  // bytes 1 to 7
  localparam logic [63:0] ACK_DATA        = 64'h01_00_00_00_00_00_00_00;
  localparam logic [63:0] STATUS_DATA     = 64'h04_03_02_01_00_00_00_00;

  typedef struct packed {
    logic        kind;
    logic [10:0] id;
    logic [3:0]  len;
    logic [63:0] data;
  } request_t;

  typedef struct packed {
    logic [10:0] id;
    logic [63:0] data;
    logic        last;
    logic        led;
  } frame_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  cwst_in_if  in_ch ();
  cwst_out_if out_ch ();

  can_wheel_steer_telemetry_gateway dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // gateway state as the testbench sees it
  cwst_pkg::cfg_t cfg_now;
  logic [31:0] now_ms;
  logic [31:0] steer_seen_ms;
  logic [31:0] tele_last_ms;
  logic [31:0] keep_last_ms;
  logic [31:0] ack_last_ms;
  logic [31:0] led_last_ms;
  logic [15:0] wheel_kmh [4];
  logic [15:0] angle_raw;
  logic        angle_fresh;
  logic        led_on;

  frame_t frames_due [$];
  int     mismatches    = 0;
  int     quiet_cycles  = 0;
  int     send_idle_pct = 0;
  int     stall_pct     = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver ready, changed on the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch in %s: expected %h, got %h", what, want, got);
  endfunction

  function automatic void push_frame(input logic [10:0] id, input logic [63:0] data);
    frame_t f;
    f.id   = id;
    f.data = data;
    f.last = 1'b0;
    f.led  = led_on;
    frames_due.push_back(f);
  endfunction

  // update the state for one accepted request and queue the frames it causes
  function automatic void predict_request(input request_t r);
    int                 first;
    logic [31:0]        prod;
    logic [15:0]        mv;
    logic signed [47:0] v;
    logic [47:0]        rounded;
    logic               keep_due;
    frame_t             f;
    if (r.kind == cwst_pkg::KIND_FRAME) begin
      if (r.id == cwst_pkg::ID_WHEEL_IN && r.len == cwst_pkg::WHEEL_LEN)
        for (int i = 0; i < 4; i++) wheel_kmh[i] = r.data[16*i +: 16];
      if (r.id == cwst_pkg::ID_STEER_IN && r.len >= cwst_pkg::STEER_MIN_LEN) begin
        angle_raw     = r.data[15:0];
        angle_fresh   = 1'b1;
        steer_seen_ms = now_ms;
      end
      return;
    end

    first  = frames_due.size();
    now_ms = now_ms + 32'd1;

    // heartbeat and stale angle
    if (now_ms - led_last_ms >= cfg_now.led_period_ms) begin
      led_last_ms = now_ms;
      led_on      = !led_on;
    end
    if (angle_fresh && (now_ms - steer_seen_ms > cfg_now.stale_timeout_ms))
      angle_fresh = 1'b0;

    // telemetry burst: four wheel frequencies then steering millivolts
    if (now_ms - tele_last_ms >= cfg_now.tele_period_ms) begin
      tele_last_ms = now_ms;
      for (int i = 0; i < 4; i++) begin
        prod = wheel_kmh[i] * cfg_now.wheel_gain + 32'd32768;
        push_frame(cwst_pkg::ID_TELE_OUT, {prod[23:16], prod[31:24], WHEEL_TELE_FILL,
                                           cwst_pkg::MUX_WHEEL + 8'(i)});
      end
      mv = cwst_pkg::MV_CENTRE;
      if (angle_fresh) begin
        v = MV_MID_Q + $signed(angle_raw) * $signed({1'b0, cfg_now.steer_gain});
        if (v < 0) v = 0;
        if (v > MV_TOP_Q) v = MV_TOP_Q;
        rounded = v + 48'd32768;
        mv = rounded[31:16];
      end
      push_frame(cwst_pkg::ID_TELE_OUT,
                 {32'h0, mv[7:0], mv[15:8], 7'h0, angle_fresh, cwst_pkg::MUX_STEER});
    end

    // keep-alive config frames, acknowledge, status
    keep_due = (now_ms - keep_last_ms >= cfg_now.keepalive_period_ms);
    if (keep_due) begin
      keep_last_ms = now_ms;
      for (int i = 0; i < 4; i++)
        push_frame(cwst_pkg::ID_CFG_OUT, {CFG_FILL, cwst_pkg::MUX_WHEEL + 8'(i)});
    end
    if (now_ms - ack_last_ms >= cfg_now.ack_period_ms) begin
      ack_last_ms = now_ms;
      push_frame(cwst_pkg::ID_ACK_OUT, ACK_DATA);
    end
    if (keep_due) push_frame(cwst_pkg::ID_STAT_OUT, STATUS_DATA);

    if (frames_due.size() > first) begin
      f = frames_due.pop_back();
      f.last = 1'b1;
      frames_due.push_back(f);
    end
  endfunction

  // one request on the input channel, with random idle cycles in front
  task automatic send_request(input request_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= r.kind;
    in_ch.frame_id   <= r.id;
    in_ch.frame_len  <= r.len;
    in_ch.frame_data <= r.data;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(r);
  endtask

  task automatic send_frame(input logic [10:0] id, input logic [3:0] len,
                            input logic [63:0] data);
    send_request('{cwst_pkg::KIND_FRAME, id, len, data});
  endtask

  task automatic send_tick();
    send_request('{cwst_pkg::KIND_TICK, 11'($urandom), 4'($urandom),
                   {$urandom, $urandom}});
  endtask

  // stop requesting and wait until every expected frame is out and the block is quiet
  task automatic drain_frames();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cwst_pkg::cfg_index_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // all seven registers, written only once the block is idle
  task automatic apply_config(input cwst_pkg::cfg_t c);
    drain_frames();
    write_reg(cwst_pkg::CFG_WHEEL_GAIN, c.wheel_gain);
    write_reg(cwst_pkg::CFG_STEER_GAIN, c.steer_gain);
    write_reg(cwst_pkg::CFG_STALE_MS, c.stale_timeout_ms);
    write_reg(cwst_pkg::CFG_TELE_MS, c.tele_period_ms);
    write_reg(cwst_pkg::CFG_KEEP_MS, c.keepalive_period_ms);
    write_reg(cwst_pkg::CFG_ACK_MS, c.ack_period_ms);
    write_reg(cwst_pkg::CFG_LED_MS, c.led_period_ms);
    @(negedge clk);
    cfg_write <= 1'b0;
    cfg_now = c;
  endtask

  // random mix: mostly ticks and well-formed wheel and steering frames, some noise
  task automatic run_traffic(input int goal);
    request_t r;
    int       pick;
    for (int n = 0; n < goal; n++) begin
      pick   = $urandom_range(99);
      r.kind = cwst_pkg::KIND_FRAME;
      r.id   = 11'($urandom);
      r.len  = 4'($urandom);
      r.data = {$urandom, $urandom};
      if (pick < 45) begin
        r.kind = cwst_pkg::KIND_TICK;
      end else if (pick < 65) begin
        r.id = cwst_pkg::ID_WHEEL_IN;
        if ($urandom_range(4) != 0) r.len = cwst_pkg::WHEEL_LEN;
      end else if (pick < 85) begin
        r.id = cwst_pkg::ID_STEER_IN;
        if ($urandom_range(4) != 0) r.len = 4'($urandom_range(15, 2));
        case ($urandom_range(5))
          0: r.data[15:0] = 16'h7FFF;
          1: r.data[15:0] = 16'h8000;
          2: r.data[15:0] = 16'($urandom_range(5400));
          3: r.data[15:0] = 16'h0 - 16'($urandom_range(5400));
          default: ;
        endcase
      end
      send_request(r);
    end
  endtask

  // wheel frames: only a length of exactly eight is latched
  task automatic test_wheel_frames();
    apply_config('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1});
    send_idle_pct = 0;
    stall_pct     = 0;
    send_frame(cwst_pkg::ID_WHEEL_IN, cwst_pkg::WHEEL_LEN, 64'hFFFF_0000_8000_0001);
    send_tick();
    send_frame(cwst_pkg::ID_WHEEL_IN, 4'd7, 64'h1111_2222_3333_4444);
    send_frame(cwst_pkg::ID_WHEEL_IN, 4'd9, 64'h5555_6666_7777_8888);
    send_tick();
  endtask

  // steering frames: length two and up, clamping at both ends, foreign ids ignored
  task automatic test_steer_frames();
    send_frame(cwst_pkg::ID_STEER_IN, cwst_pkg::STEER_MIN_LEN, 64'hA5A5_A5A5_A5A5_7FFF);
    send_tick();
    send_frame(cwst_pkg::ID_STEER_IN, 4'd15, 64'h5A5A_5A5A_5A5A_8000);
    send_tick();
    send_frame(cwst_pkg::ID_STEER_IN, 4'd1, 64'h0000_0000_0000_0001);
    send_tick();
    send_frame(11'h0C5, cwst_pkg::WHEEL_LEN, 64'h0);
    send_frame(11'h7FF, cwst_pkg::WHEEL_LEN, '1);
    send_frame(11'h000, 4'd0, 64'h0);
    send_frame(cwst_pkg::ID_STEER_IN, 4'd3, 64'h0000_0000_0000_FFFF);
    send_tick();
  endtask

  // angle goes stale after the timeout; some ticks send nothing at all
  task automatic test_stale_and_quiet_ticks();
    apply_config('{16'd0, 16'd0, 16'd2, 16'd3, 16'd5, 16'd4, 16'd2});
    send_frame(cwst_pkg::ID_STEER_IN, cwst_pkg::WHEEL_LEN, 64'h0000_0000_0000_1234);
    repeat (4) send_tick();
    send_frame(cwst_pkg::ID_WHEEL_IN, cwst_pkg::WHEEL_LEN, {$urandom, $urandom});
    repeat (3) send_tick();
  endtask

  // period zero: telemetry on every tick, bursts back to back
  task automatic test_traffic_no_idling();
    apply_config('{16'($urandom), 16'($urandom), 16'd0, 16'd0, 16'd2, 16'd3, 16'd1});
    send_idle_pct = 0;
    stall_pct     = 0;
    run_traffic(21);
  endtask

  task automatic test_traffic_sender_idle();
    apply_config('{16'd1, 16'd1, 16'hFFFF, 16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_idle_pct = 78;
    stall_pct     = 0;
    run_traffic(21);
  endtask

  task automatic test_traffic_receiver_stall();
    apply_config('{cwst_pkg::RST_WHEEL_GAIN, cwst_pkg::RST_STEER_GAIN, 16'd10, 16'd1,
                   16'd4, 16'd1, 16'd3});
    send_idle_pct = 0;
    stall_pct     = 78;
    run_traffic(21);
  endtask

  task automatic test_traffic_both_idle();
    apply_config('{16'($urandom), 16'($urandom), 16'($urandom_range(8)),
                   16'($urandom_range(3, 1)), 16'($urandom_range(6, 1)),
                   16'($urandom_range(6, 1)), 16'($urandom_range(4, 1))});
    send_idle_pct = 32;
    stall_pct     = 32;
    run_traffic(21);
  endtask

  // compare each accepted frame with the oldest expected one
  always @(posedge clk) begin : check_frames
    frame_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (frames_due.size() == 0) begin
        note_mismatch("frame with none expected, out_data", '0, out_ch.out_data);
      end else begin
        want = frames_due.pop_front();
        if (out_ch.out_id !== want.id)
          note_mismatch("out_id", 64'(want.id), 64'(out_ch.out_id));
        if (out_ch.out_data !== want.data)
          note_mismatch("out_data", want.data, out_ch.out_data);
        if (out_ch.last_frame !== want.last)
          note_mismatch("last_frame", 64'(want.last), 64'(out_ch.last_frame));
        if (out_ch.led_level !== want.led)
          note_mismatch("led_level", 64'(want.led), 64'(out_ch.led_level));
      end
    end
  end

  // watchdog on cycles with no request or frame moving
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // reset, then the tests in turn
  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = cwst_pkg::CFG_WHEEL_GAIN;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = cwst_pkg::KIND_FRAME;
    in_ch.frame_id   = '0;
    in_ch.frame_len  = '0;
    in_ch.frame_data = '0;
    cfg_now = '{cwst_pkg::RST_WHEEL_GAIN, cwst_pkg::RST_STEER_GAIN, cwst_pkg::RST_STALE_MS,
                cwst_pkg::RST_TELE_MS, cwst_pkg::RST_KEEP_MS, cwst_pkg::RST_ACK_MS,
                cwst_pkg::RST_LED_MS};
    now_ms        = '0;
    steer_seen_ms = '0;
    tele_last_ms  = '0;
    keep_last_ms  = '0;
    ack_last_ms   = '0;
    led_last_ms   = '0;
    angle_raw     = '0;
    angle_fresh   = 1'b0;
    led_on        = 1'b0;
    for (int i = 0; i < 4; i++) wheel_kmh[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_wheel_frames();
    test_steer_frames();
    test_stale_and_quiet_ticks();
    test_traffic_no_idling();
    test_traffic_sender_idle();
    test_traffic_receiver_stall();
    test_traffic_both_idle();

    drain_frames();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> files.f
rtl/cwst_pkg.sv
rtl/cwst_if.sv
rtl/cwst_front.sv
rtl/cwst_queue.sv
rtl/cwst_back.sv
rtl/can_wheel_steer_telemetry_gateway.sv
test/can_wheel_steer_telemetry_gateway_tb.sv
